// ----- rtl/dza_pkg.sv -----
`default_nettype none
package dza_pkg;

  localparam int unsigned ARENA_BYTES = 32768;
  localparam int unsigned ZONE_DEPTH  = 64;
  localparam int unsigned WORD_BYTES  = 8;

  localparam int unsigned TAG_COUNT  = ARENA_BYTES / WORD_BYTES;
  localparam int unsigned TAG_IDX_W  = $clog2(TAG_COUNT);
  localparam int unsigned ZONE_W     = $clog2(ZONE_DEPTH);
  localparam int unsigned WORD_SHIFT = $clog2(WORD_BYTES);

  localparam int unsigned FUNC_W = 3;
  localparam int unsigned OFF_W  = 16;
  localparam int unsigned ERR_W  = 3;
  localparam int unsigned CALC_W = OFF_W + 2;

  localparam logic [OFF_W-1:0] WORD_OFF  = OFF_W'(WORD_BYTES);
  localparam logic [OFF_W-1:0] ARENA_OFF = OFF_W'(ARENA_BYTES);

  localparam logic [FUNC_W-1:0] FN_ALLOC_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_PUSH_ZONE   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_ZONE    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_ALLOC_BACK  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_POP_BACK    = 3'd5;

  localparam logic [ERR_W-1:0] ERR_OK    = 3'd0;
  localparam logic [ERR_W-1:0] ERR_OOM   = 3'd1;
  localparam logic [ERR_W-1:0] ERR_ADDR  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_FULL  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [OFF_W-1:0]  req_size;
    logic [OFF_W-1:0]  block_addr;
  } in_word_t;

  typedef struct packed {
    logic [OFF_W-1:0] alloc_addr;
    logic [ERR_W-1:0] error;
    logic [OFF_W-1:0] used_bytes;
  } out_word_t;

endpackage
`default_nettype wire

// ----- rtl/double_ended_zone_arena.sv -----
// Bookkeeping for a double-ended arena of byte offsets with 8-byte words.
// The request channel (req_valid, req_stall, req_word) carries one operation:
// front or back allocation, front or back pop, zone push or zone pop.
// The response channel (rsp_valid, rsp_stall, rsp_word) returns one word per
// request with the block address, an error code and the bytes in use.
// A request is taken at an edge where req_valid is high and req_stall low.
// On that edge the size tag and zone mark memories are read; in the execute
// state, once the response register is free, the pointers are updated, the
// memories written and the response loaded together.
// One request is in work at a time: the block takes no new request until
// the update that follows the registered read of the tag memory is done.
// If the response register still holds an unaccepted word, the update waits
// until rsp_stall drops; req_stall stays high meanwhile.
// Reset sets the head to zero, the tail to the arena end and empties the zone
// stack. Memory contents are not cleared, and no clearing pass is needed:
// every tag and mark is written before it can legally be read.
`default_nettype none
module double_ended_zone_arena (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  dza_pkg::in_word_t   req_word,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output dza_pkg::out_word_t  rsp_word
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                             state;
  dza_pkg::in_word_t                  item;
  logic [dza_pkg::OFF_W-1:0]          head;
  logic [dza_pkg::OFF_W-1:0]          tail;
  logic [dza_pkg::ZONE_W-1:0]         top;

  logic                               req_fire;
  logic                               exec_go;
  logic [dza_pkg::OFF_W-1:0]          head_m8;
  logic [dza_pkg::TAG_IDX_W-1:0]      tag_raddr;
  logic [dza_pkg::OFF_W-1:0]          tag_rdata;
  logic [dza_pkg::OFF_W-1:0]          mark_rdata;

  logic                               tag_we;
  logic [dza_pkg::TAG_IDX_W-1:0]      tag_waddr;
  logic [dza_pkg::OFF_W-1:0]          tag_wdata;
  logic                               mark_we;
  logic [dza_pkg::ZONE_W-1:0]         mark_waddr;

  logic [dza_pkg::OFF_W-1:0]          head_next;
  logic [dza_pkg::OFF_W-1:0]          tail_next;
  logic [dza_pkg::ZONE_W-1:0]         top_next;
  dza_pkg::out_word_t                 rsp_next;

  logic [dza_pkg::CALC_W-1:0]         rnd;
  logic [dza_pkg::CALC_W-1:0]         rnd_tag;
  logic [dza_pkg::CALC_W-1:0]         head_c;
  logic [dza_pkg::CALC_W-1:0]         tail_c;
  logic [dza_pkg::CALC_W-1:0]         front_tag;
  logic [dza_pkg::CALC_W-1:0]         front_end;
  logic [dza_pkg::CALC_W-1:0]         back_base;
  logic [dza_pkg::OFF_W-1:0]          tpos;
  logic [dza_pkg::ZONE_W:0]           top_inc;
  logic [dza_pkg::ERR_W-1:0]          err;
  logic [dza_pkg::OFF_W-1:0]          addr;

  assign req_stall = (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign exec_go   = (state == S_EXEC) && (!rsp_valid || !rsp_stall);

  assign head_m8   = head - dza_pkg::WORD_OFF;
  assign tag_raddr = (req_word.func == dza_pkg::FN_POP_BACK)
                   ? tail[dza_pkg::WORD_SHIFT +: dza_pkg::TAG_IDX_W]
                   : head_m8[dza_pkg::WORD_SHIFT +: dza_pkg::TAG_IDX_W];

  dza_ram #(.WIDTH(dza_pkg::OFF_W), .DEPTH(dza_pkg::TAG_COUNT)) u_tags (
    .clk   (clk),
    .we    (tag_we && exec_go),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .re    (req_fire),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  dza_ram #(.WIDTH(dza_pkg::OFF_W), .DEPTH(dza_pkg::ZONE_DEPTH)) u_marks (
    .clk   (clk),
    .we    (mark_we && exec_go),
    .waddr (mark_waddr),
    .wdata (head),
    .re    (req_fire),
    .raddr (top),
    .rdata (mark_rdata)
  );

  always_comb begin
    rnd = (dza_pkg::CALC_W'(item.req_size) + dza_pkg::CALC_W'(dza_pkg::WORD_BYTES - 1))
        & ~dza_pkg::CALC_W'(dza_pkg::WORD_BYTES - 1);
    rnd_tag   = rnd + dza_pkg::CALC_W'(dza_pkg::WORD_BYTES);
    head_c    = dza_pkg::CALC_W'(head);
    tail_c    = dza_pkg::CALC_W'(tail);
    front_tag = head_c + rnd;
    front_end = head_c + rnd_tag;
    back_base = tail_c - rnd_tag;
    tpos      = head_m8;
    top_inc   = (dza_pkg::ZONE_W + 1)'(top) + (dza_pkg::ZONE_W + 1)'(1);

    err        = dza_pkg::ERR_OK;
    addr       = '0;
    head_next  = head;
    tail_next  = tail;
    top_next   = top;
    tag_we     = 1'b0;
    tag_waddr  = front_tag[dza_pkg::WORD_SHIFT +: dza_pkg::TAG_IDX_W];
    tag_wdata  = rnd[dza_pkg::OFF_W-1:0];
    mark_we    = 1'b0;
    mark_waddr = top_inc[dza_pkg::ZONE_W-1:0];

    case (item.func)
      dza_pkg::FN_ALLOC_FRONT: begin
        if (front_end > tail_c) begin
          err = dza_pkg::ERR_OOM;
        end else begin
          addr      = head;
          tag_we    = 1'b1;
          head_next = front_end[dza_pkg::OFF_W-1:0];
        end
      end
      dza_pkg::FN_POP_FRONT: begin
        if (head < dza_pkg::WORD_OFF || tag_rdata > tpos
            || (tpos - tag_rdata) != item.block_addr) begin
          err = dza_pkg::ERR_ADDR;
        end else begin
          head_next = tpos - tag_rdata;
        end
      end
      dza_pkg::FN_PUSH_ZONE: begin
        if (top_inc >= (dza_pkg::ZONE_W + 1)'(dza_pkg::ZONE_DEPTH)) begin
          err = dza_pkg::ERR_FULL;
        end else begin
          top_next = top_inc[dza_pkg::ZONE_W-1:0];
          mark_we  = 1'b1;
        end
      end
      dza_pkg::FN_POP_ZONE: begin
        if (top == '0) begin
          err = dza_pkg::ERR_EMPTY;
        end else if (head < mark_rdata) begin
          err = dza_pkg::ERR_ADDR;
        end else begin
          head_next = mark_rdata;
          top_next  = top - dza_pkg::ZONE_W'(1);
        end
      end
      dza_pkg::FN_ALLOC_BACK: begin
        if (rnd_tag > tail_c || back_base < head_c) begin
          err = dza_pkg::ERR_OOM;
        end else begin
          tail_next = back_base[dza_pkg::OFF_W-1:0];
          tag_we    = 1'b1;
          tag_waddr = back_base[dza_pkg::WORD_SHIFT +: dza_pkg::TAG_IDX_W];
          tag_wdata = rnd_tag[dza_pkg::OFF_W-1:0];
          addr      = back_base[dza_pkg::OFF_W-1:0] + dza_pkg::WORD_OFF;
        end
      end
      dza_pkg::FN_POP_BACK: begin
        if (tail >= dza_pkg::ARENA_OFF
            || tail_c + dza_pkg::CALC_W'(dza_pkg::WORD_BYTES)
               != dza_pkg::CALC_W'(item.block_addr)) begin
          err = dza_pkg::ERR_ADDR;
        end else if (dza_pkg::CALC_W'(tag_rdata)
                     > dza_pkg::CALC_W'(dza_pkg::ARENA_BYTES) - tail_c) begin
          err = dza_pkg::ERR_ADDR;
        end else begin
          tail_next = tail + tag_rdata;
        end
      end
      default: begin
      end
    endcase

    rsp_next.alloc_addr = addr;
    rsp_next.error      = err;
    rsp_next.used_bytes = dza_pkg::ARENA_OFF - (tail_next - head_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= dza_pkg::ARENA_OFF;
      top       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            state <= S_IDLE;
            head  <= head_next;
            tail  <= tail_next;
            top   <= top_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (exec_go) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      item <= req_word;
    end
    if (exec_go) begin
      rsp_word <= rsp_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_head_below_tail: assert property (@(posedge clk) disable iff (rst)
    head <= tail)
    else $error("head offset passed tail offset");

  a_tail_in_arena: assert property (@(posedge clk) disable iff (rst)
    tail <= dza_pkg::ARENA_OFF)
    else $error("tail offset beyond arena end");

  a_zone_top_bound: assert property (@(posedge clk) disable iff (rst)
    top == $past(top) || top == $past(top) + dza_pkg::ZONE_W'(1)
    || top == $past(top) - dza_pkg::ZONE_W'(1))
    else $error("zone stack pointer moved by more than one entry");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> !req_fire && state == S_EXEC)
    else $error("second request taken while one is in work");

  a_addr_only_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_word.alloc_addr != '0 |-> rsp_word.error == dza_pkg::ERR_OK)
    else $error("block address returned with an error");
`endif

endmodule
`default_nettype wire

// ----- rtl/dza_ram.sv -----
`default_nettype none
module dza_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
